/* rtl/u8d_pkg.sv */
`timescale 1ns / 1ps
package u8d_pkg;

  localparam int CpWidth = 21;

  localparam logic [CpWidth-1:0] Replacement = 21'h00FFFD;
  localparam logic [CpWidth-1:0] MaxScalar   = 21'h10FFFF;
  localparam logic [CpWidth-1:0] SurrLow     = 21'h00D800;
  localparam logic [CpWidth-1:0] SurrHigh    = 21'h00DFFF;

  localparam logic [7:0] Lead4Min = 8'hF0;
  localparam logic [7:0] Lead3Min = 8'hE0;
  localparam logic [7:0] Lead2Min = 8'hC0;
  localparam logic [7:0] ContMin  = 8'h80;

  localparam logic [2:0] SeqNone = 3'd0;
  localparam logic [2:0] SeqTwo  = 3'd2;
  localparam logic [2:0] SeqThree = 3'd3;
  localparam logic [2:0] SeqFour = 3'd4;

  typedef logic [2:0] beats_t;

  // One classified byte: (beats - 1) replacement beats, then the final beat.
  typedef struct packed {
    beats_t              beats;
    logic [CpWidth-1:0]  final_cp;
    logic                final_rep;
    logic                eot;
  } cmd_t;

endpackage

/* rtl/u8d_front.sv */
`timescale 1ns / 1ps
module u8d_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    data_byte_i,
  input  logic          end_of_text_i,
  input  logic          q_ready_i,
  output logic          q_push_o,
  output u8d_pkg::cmd_t q_cmd_o
);
  import u8d_pkg::*;

  logic [2:0]         len_q, len_d;
  logic [1:0]         held_q, held_d;
  logic [CpWidth-1:0] acc_q, acc_d;

  logic               accept;
  logic               is_ascii, is_cont;
  logic [2:0]         lead_len;
  logic [CpWidth-1:0] lead_acc;
  logic [CpWidth-1:0] shifted;
  logic [1:0]         held_inc;
  beats_t             flush_n;
  cmd_t               cmd;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;

  assign is_ascii = data_byte_i < ContMin;
  assign is_cont  = (data_byte_i >= ContMin) && (data_byte_i < Lead2Min);
  assign shifted  = {acc_q[CpWidth-7:0], data_byte_i[5:0]};
  assign held_inc = held_q + 2'd1;
  assign flush_n  = {1'b0, held_q} + 3'd1;

  always_comb begin
    priority if (data_byte_i >= Lead4Min) begin
      lead_len = SeqFour;
      lead_acc = {{(CpWidth-3){1'b0}}, data_byte_i[2:0]};
    end else if (data_byte_i >= Lead3Min) begin
      lead_len = SeqThree;
      lead_acc = {{(CpWidth-4){1'b0}}, data_byte_i[3:0]};
    end else begin
      lead_len = SeqTwo;
      lead_acc = {{(CpWidth-5){1'b0}}, data_byte_i[4:0]};
    end
  end

  always_comb begin
    len_d  = len_q;
    held_d = held_q;
    acc_d  = acc_q;
    cmd.beats     = 3'd0;
    cmd.final_cp  = Replacement;
    cmd.final_rep = 1'b1;
    cmd.eot       = end_of_text_i;

    if (len_q != SeqNone) begin
      if (is_cont) begin
        acc_d  = shifted;
        held_d = held_inc;
        if (({1'b0, held_inc} + 3'd1) >= len_q) begin
          cmd.beats = 3'd1;
          if (!((shifted > MaxScalar) || ((shifted >= SurrLow) && (shifted <= SurrHigh)))) begin
            cmd.final_cp  = shifted;
            cmd.final_rep = 1'b0;
          end
          len_d  = SeqNone;
          held_d = 2'd0;
          acc_d  = '0;
        end else if (end_of_text_i) begin
          // cut off at end: lead plus every held continuation
          cmd.beats = {1'b0, held_inc} + 3'd1;
          len_d  = SeqNone;
          held_d = 2'd0;
          acc_d  = '0;
        end
      end else if (is_ascii) begin
        cmd.beats     = flush_n + 3'd1;
        cmd.final_cp  = {{(CpWidth-8){1'b0}}, data_byte_i};
        cmd.final_rep = 1'b0;
        len_d  = SeqNone;
        held_d = 2'd0;
        acc_d  = '0;
      end else begin
        // broken by a new lead: flush the old one, open the new one (or flush it too at end of text)
        len_d  = lead_len;
        held_d = 2'd0;
        acc_d  = lead_acc;
        cmd.beats = flush_n;
        if (end_of_text_i) begin
          cmd.beats = flush_n + 3'd1;
          len_d  = SeqNone;
          acc_d  = '0;
        end
      end
    end else if (is_ascii) begin
      cmd.beats     = 3'd1;
      cmd.final_cp  = {{(CpWidth-8){1'b0}}, data_byte_i};
      cmd.final_rep = 1'b0;
    end else if (is_cont) begin
      cmd.beats = 3'd1;
    end else if (end_of_text_i) begin
      cmd.beats = 3'd1;
    end else begin
      len_d  = lead_len;
      held_d = 2'd0;
      acc_d  = lead_acc;
    end
  end

  assign q_push_o = accept && (cmd.beats != 3'd0);
  assign q_cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= SeqNone;
      held_q <= 2'd0;
      acc_q  <= '0;
    end else if (accept) begin
      len_q  <= len_d;
      held_q <= held_d;
      acc_q  <= acc_d;
    end
  end

endmodule

/* rtl/u8d_queue.sv */
`timescale 1ns / 1ps
module u8d_queue #(
  parameter int Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          ready_o,
  input  u8d_pkg::cmd_t cmd_i,
  output logic          valid_o,
  input  logic          pop_i,
  output u8d_pkg::cmd_t cmd_o
);
  import u8d_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign ready_o = count_q != Full;
  assign valid_o = count_q != '0;
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/u8d_back.sv */
`timescale 1ns / 1ps
module u8d_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  u8d_pkg::cmd_t               q_cmd_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [u8d_pkg::CpWidth-1:0] code_point_o,
  output logic                        replaced_o,
  output logic                        last_of_run_o,
  output logic                        text_done_o
);
  import u8d_pkg::*;

  logic   busy_q;
  beats_t left_q;
  cmd_t   cur_q;
  logic   on_last;
  logic   load;

  assign on_last = left_q == 3'd1;
  // take the next beat group when idle or when the final beat leaves
  assign load    = q_valid_i && (!busy_q || (out_ready_i && on_last));
  assign q_pop_o = load;

  assign out_valid_o   = busy_q;
  assign code_point_o  = on_last ? cur_q.final_cp : Replacement;
  assign replaced_o    = on_last ? cur_q.final_rep : 1'b1;
  assign last_of_run_o = on_last;
  assign text_done_o   = cur_q.eot;

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      left_q <= 3'd0;
    end else if (load) begin
      busy_q <= 1'b1;
      left_q <= q_cmd_i.beats;
    end else if (busy_q && out_ready_i) begin
      if (on_last) begin
        busy_q <= 1'b0;
      end
      left_q <= left_q - 3'd1;
    end
  end

endmodule

/* rtl/utf8_stream_decoder.sv */
`timescale 1ns / 1ps
// UTF-8 byte stream to code point stream.
// Input channel: one byte per beat on data_byte_i, end_of_text_i set on the
// final byte of a text. Output channel: one code point per beat, with
// replaced_o for U+FFFD substitutions, last_of_run_o on the final result of
// an input byte and text_done_o copied from that byte's end_of_text_i.
// A byte gives zero to four results; bytes that only open or extend a
// sequence give none.
// A byte's results are registered in the queue, then in the output stage.
// Throughput: one byte per cycle while bytes give at most one result each
// and out_ready_i stays high; the output port emits one result per cycle
// while out_ready_i is high, so a byte with k results holds the output for
// k beats. A queue of QueueDepth classified bytes sits between the decoder
// front and the output stage; the input only stalls once that queue is full.
// When the receiver stalls, results wait in the output stage and queue;
// in_ready_o drops only when the queue fills.
// Reset closes any open sequence and empties the queue and output stage.
module utf8_stream_decoder #(
  parameter int QueueDepth = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        end_of_text_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [u8d_pkg::CpWidth-1:0] code_point_o,
  output logic                        replaced_o,
  output logic                        last_of_run_o,
  output logic                        text_done_o
);
  import u8d_pkg::*;

  logic q_push, q_ready, q_valid, q_pop;
  cmd_t push_cmd, pop_cmd;

  u8d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .end_of_text_i (end_of_text_i),
    .q_ready_i     (q_ready),
    .q_push_o      (q_push),
    .q_cmd_o       (push_cmd)
  );

  u8d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .ready_o (q_ready),
    .cmd_i   (push_cmd),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (pop_cmd)
  );

  u8d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cmd_i       (pop_cmd),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_point_o  (code_point_o),
    .replaced_o    (replaced_o),
    .last_of_run_o (last_of_run_o),
    .text_done_o   (text_done_o)
  );

endmodule

/* tb/tb_utf8_stream_decoder.sv */
`timescale 1ns / 1ps
module tb_utf8_stream_decoder;
  import u8d_pkg::*;

  localparam int IdleLimit   = 400;
  localparam int DrainCycles = 20;
  localparam int RandomBytes = 344;

  typedef struct packed {
    logic [CpWidth-1:0] cp;
    logic               rep;
    logic               last;
    logic               done;
  } cp_result_t;

  // Tracks the open sequence and holds the code points still due from the block.
  class CodePointTracker;
    cp_result_t         expected_cps[$];
    cp_result_t         run_cps[$];
    logic [2:0]         seq_len;
    logic [1:0]         held;
    logic [CpWidth-1:0] acc;
    int unsigned        errors;

    function new();
      seq_len = SeqNone;
      held    = '0;
      acc     = '0;
      errors  = 0;
    endfunction

    function void add_cp(logic [CpWidth-1:0] cp, logic rep);
      cp_result_t r;
      r.cp   = cp;
      r.rep  = rep;
      r.last = 1'b0;
      r.done = 1'b0;
      run_cps.push_back(r);
    endfunction

    // One replacement for the lead and one per held continuation, then close.
    function void close_open();
      for (int k = 0; k <= held && run_cps.size() < 4; k++) begin
        add_cp(Replacement, 1'b1);
      end
      seq_len = SeqNone;
      held    = '0;
      acc     = '0;
    endfunction

    function void open_fresh(logic [7:0] b);
      if (b < ContMin) begin
        add_cp(CpWidth'(b), 1'b0);
      end else if (b < Lead2Min) begin
        add_cp(Replacement, 1'b1);
      end else begin
        held = '0;
        if (b >= Lead4Min) begin
          seq_len = SeqFour;
          acc     = CpWidth'(b[2:0]);
        end else if (b >= Lead3Min) begin
          seq_len = SeqThree;
          acc     = CpWidth'(b[3:0]);
        end else begin
          seq_len = SeqTwo;
          acc     = CpWidth'(b[4:0]);
        end
      end
    endfunction

    function void note_byte(logic [7:0] b, logic eot);
      logic [CpWidth-1:0] v;
      cp_result_t         r;
      run_cps.delete();
      if (seq_len != SeqNone) begin
        if (b >= ContMin && b < Lead2Min) begin
          acc  = {acc[CpWidth-7:0], b[5:0]};
          held = held + 2'd1;
          if ({1'b0, held} + 3'd1 >= seq_len) begin
            v = acc;
            if (v > MaxScalar || (v >= SurrLow && v <= SurrHigh)) begin
              add_cp(Replacement, 1'b1);
            end else begin
              add_cp(v, 1'b0);
            end
            seq_len = SeqNone;
            held    = '0;
            acc     = '0;
          end
        end else begin
          // Broken sequence: flush it, then decode the breaking byte afresh.
          close_open();
          open_fresh(b);
        end
      end else begin
        open_fresh(b);
      end
      if (eot && seq_len != SeqNone) begin
        close_open();
      end
      foreach (run_cps[i]) begin
        r      = run_cps[i];
        r.done = eot;
        r.last = (i == run_cps.size() - 1);
        expected_cps.push_back(r);
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [CpWidth-1:0] cp, logic rep, logic last, logic done);
      cp_result_t want;
      if (expected_cps.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat: expected none, actual code point %0h", $time, cp);
        return;
      end
      want = expected_cps.pop_front();
      compare_field("code_point", want.cp, cp);
      compare_field("replaced", want.rep, rep);
      compare_field("last_of_run", want.last, last);
      compare_field("text_done", want.done, done);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         data_byte_i;
  logic               end_of_text_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [CpWidth-1:0] code_point_o;
  logic               replaced_o;
  logic               last_of_run_o;
  logic               text_done_o;

  CodePointTracker track;
  bit              send_burst;
  bit              recv_burst;

  // Extremes, every sequence length, stray and broken sequences, surrogate,
  // out of range with an 0xF8+ lead, and a sequence cut off at end of text.
  localparam logic [8:0] DirectedText [26] = '{
    9'h000, 9'h17F, 9'h080, 9'h0C3, 9'h0A9, 9'h0E2, 9'h082, 9'h0AC,
    9'h0F0, 9'h09F, 9'h098, 9'h080, 9'h0ED, 9'h0A0, 9'h080, 9'h0FF,
    9'h0BF, 9'h0BF, 9'h0BF, 9'h0E2, 9'h082, 9'h041, 9'h0F0, 9'h09F,
    9'h098, 9'h1C3
  };

  utf8_stream_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_point_o  (code_point_o),
    .replaced_o    (replaced_o),
    .last_of_run_o (last_of_run_o),
    .text_done_o   (text_done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Keep valid high across back-to-back beats; drop it only ahead of a gap.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (!in_ready_o);
    track.note_byte(b, eot);
  endtask

  // Mostly well-formed sequences with random payload, plus cut-short ones and noise.
  task automatic send_random_text(input int unsigned target);
    int unsigned sent;
    int unsigned next_mode;
    int unsigned kind;
    int unsigned len;
    int unsigned conts;
    logic [7:0]  lead;
    sent      = 0;
    next_mode = 0;
    while (sent < target) begin
      if (sent >= next_mode) begin
        send_burst = ($urandom_range(0, 3) == 0);
        next_mode  = sent + 40;
      end
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
        sent++;
      end else begin
        len = $urandom_range(1, 4);
        case (len)
          1: lead = 8'($urandom_range(0, 127));
          2: lead = Lead2Min | 8'($urandom_range(0, 31));
          3: lead = Lead3Min | 8'($urandom_range(0, 15));
          default: lead = 8'($urandom_range(Lead4Min, 8'hFF));
        endcase
        conts = len - 1;
        if (kind < 30 && len > 1) begin
          conts = $urandom_range(0, len - 2);
        end
        send_byte(lead, $urandom_range(0, 19) == 0);
        sent++;
        repeat (conts) begin
          send_byte(ContMin | 8'($urandom_range(0, 63)), $urandom_range(0, 19) == 0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int          gap;
    int unsigned taken;
    taken = 0;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken % 32 == 0) begin
        recv_burst = ($urandom_range(0, 3) == 0);
      end
      gap = recv_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      track.check_result(code_point_o, replaced_o, last_of_run_o, text_done_o);
      taken++;
    end
  end

  initial begin
    track         = new();
    send_burst    = 1'b0;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    data_byte_i   <= '0;
    end_of_text_i <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedText[i]) begin
      send_byte(DirectedText[i][7:0], DirectedText[i][8]);
    end
    send_random_text(RandomBytes);
    in_valid_i <= 1'b0;

    while (track.expected_cps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (track.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/u8d_pkg.sv
rtl/u8d_front.sv
rtl/u8d_queue.sv
rtl/u8d_back.sv
rtl/utf8_stream_decoder.sv
tb/tb_utf8_stream_decoder.sv
